>>> rtl/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared codes, field widths and controller/datapath interface types for the
// priority queue scheduler.
// ----------------------------------------------------------------------------
package pqs_pkg;

    localparam int VALUE_W   = 32;
    localparam int IN_PRIO_W = 8;
    localparam int OCC_W     = 5;
    localparam int STATUS_W  = 2;

    // operation codes (slave tuser)
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result status codes (master tuser)
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic enq;         // enqueue beat accepted
        logic deq;         // dequeue beat accepted
        logic rd_issue;    // issue a store read at the read index, advance index
        logic scan;        // returning read data feeds the max search
        logic shift;       // returning read data moves down one slot
        logic shift_start; // latch winner, point read index past it
        logic deq_finish;  // drop one entry from the count
        logic load_out;    // move pending result to the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic rd_more;     // read index still below the count
        logic rd_pend;     // a read is in flight
        logic out_free;    // output register can take a result this cycle
    } t_sts;

endpackage

>>> rtl/pqs_ram.sv
// ----------------------------------------------------------------------------
// pqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pqs_ctrl.sv
// ----------------------------------------------------------------------------
// pqs_ctrl
// Sequencer: accept, max scan, gap close, result hand-off.
// ----------------------------------------------------------------------------
module pqs_ctrl
    import pqs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    input  logic i_op,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.enq = (i_op == OP_ENQ);
                    o_cmd.deq = (i_op == OP_DEQ);
                    if (i_op == OP_DEQ && !i_sts.empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.rd_issue = i_sts.rd_more;
                if (!i_sts.rd_more && !i_sts.rd_pend) begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift    = 1'b1;
                o_cmd.rd_issue = i_sts.rd_more;
                if (!i_sts.rd_more && !i_sts.rd_pend) begin
                    o_cmd.deq_finish = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/pqs_dp.sv
// ----------------------------------------------------------------------------
// pqs_dp
// Entry store, count, read pipeline, best-entry tracker and result registers.
// ----------------------------------------------------------------------------
module pqs_dp
    import pqs_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [IN_PRIO_W-1:0]       i_prio,
    input  logic                       i_m_ready,
    output logic                       o_m_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic [OCC_W-1:0]           o_occ
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = VALUE_W + PRIORITY_BITS;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_rd_idx;
    logic                     r_pend;
    logic [IW-1:0]            r_pend_idx;
    logic [IW-1:0]            r_best_idx;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic [VALUE_W-1:0]       r_best_val;
    logic [STATUS_W-1:0]      r_res_status;
    logic [VALUE_W-1:0]       r_res_value;
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic [VALUE_W-1:0]       r_out_value;
    logic [OCC_W-1:0]         r_out_occ;

    logic                     full;
    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;
    logic [EW-1:0]            mem_wdata;
    logic [EW-1:0]            mem_rdata;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [VALUE_W-1:0]       rd_val;
    logic                     take;

    assign full    = (r_count == CW'(DEPTH));
    assign rd_prio = mem_rdata[EW-1:VALUE_W];
    assign rd_val  = mem_rdata[VALUE_W-1:0];
    assign take    = (r_pend_idx == '0) || (rd_prio > r_best_prio);

    // enqueue writes at the young end; gap close writes each entry one slot down
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[IW-1:0];
        mem_wdata = {PRIORITY_BITS'(i_prio), i_value};
        if (i_cmd.enq && !full) begin
            mem_we = 1'b1;
        end else if (i_cmd.shift && r_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_pend_idx - IW'(1);
            mem_wdata = mem_rdata;
        end
    end

    pqs_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_issue;
            if (i_cmd.enq && !full) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.deq_finish) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq) begin
            r_res_status <= full ? ST_FULL : ST_OK;
            r_res_value  <= '0;
        end
        if (i_cmd.deq) begin
            r_res_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
            r_res_value  <= '0;
            r_rd_idx     <= '0;
        end else if (i_cmd.shift_start) begin
            r_res_value <= r_best_val;
            r_rd_idx    <= CW'(r_best_idx) + CW'(1);
        end else if (i_cmd.rd_issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        if (i_cmd.rd_issue) begin
            r_pend_idx <= r_rd_idx[IW-1:0];
        end
        // strict greater-than from the oldest slot keeps the oldest on a tie
        if (i_cmd.scan && r_pend && take) begin
            r_best_idx  <= r_pend_idx;
            r_best_prio <= rd_prio;
            r_best_val  <= rd_val;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.rd_more  = (r_rd_idx < r_count);
    assign o_sts.rd_pend  = r_pend;
    assign o_sts.out_free = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_status  = r_out_status;
    assign o_value   = r_out_value;
    assign o_occ     = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift && r_pend |-> (CW'(r_pend_idx) < r_count) && (r_pend_idx != '0))
        else $error("gap close read outside held entries");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_res_status == ST_FULL |-> full)
        else $error("full status with free slots");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_res_status == ST_EMPTY |-> r_count == '0)
        else $error("empty status with held entries");

    a_deq_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deq_finish |=> r_count == $past(r_count) - CW'(1))
        else $error("dequeue did not remove exactly one entry");

endmodule

>>> rtl/priority_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_queue_scheduler_unit
// Bounded priority queue, oldest entry first among equal priorities.
// ----------------------------------------------------------------------------
// Slave stream: one beat per command. tuser[0] is the operation (0 enqueue,
// 1 dequeue); tdata carries the value and the priority, ignored on dequeue.
// Master stream: one beat per command. tuser is the status (ok, full with
// the enqueue dropped, empty on dequeue); tdata carries the removed value
// (zero unless a dequeue succeeded) and the occupancy after the command.
// Commands are handled one at a time. An enqueue, or a dequeue on an empty
// queue, goes to the output register once that register is free, and the
// next command is taken after that. A dequeue of n held entries reads
// every entry once through the single store read port to find the winner,
// then moves each younger entry down one slot and loads the result.
// Reset empties the queue and the output register; stored entries are not
// cleared. A new command is accepted while a finished result still waits on
// the master side; a further result then holds until that beat is taken.
// ----------------------------------------------------------------------------
module priority_queue_scheduler_unit
    import pqs_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] item_value, [39:32] item_priority
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_value, [36:32] occupancy, rest 0
    output logic [1:0]  m_tuser    // [1:0] status
);

    t_cmd                      cmd;
    t_sts                      sts;
    logic signed [VALUE_W-1:0] out_value;
    logic [OCC_W-1:0]          out_occ;

    pqs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_op      (s_tuser[0]),
        .o_s_ready (s_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    pqs_dp #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_value   (s_tdata[31:0]),
        .i_prio    (s_tdata[39:32]),
        .i_m_ready (m_tready),
        .o_m_valid (m_tvalid),
        .o_status  (m_tuser),
        .o_value   (out_value),
        .o_occ     (out_occ)
    );

    assign m_tdata = {3'b000, out_occ, out_value};

endmodule
